FILE: hw/rtl/bui_pkg.sv
// shared types and constants of the bilinear integer upscaler
package bui_pkg;

    // fixed field widths
    localparam int ROW_W      = 11;
    localparam int PIX_W      = 8;
    localparam int SCALE_W    = 4;
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // sequencing lengths
    localparam int DIV_STEPS = ROW_W;
    localparam int Q_STEPS   = PIX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SCALE  = 2'd0;
    localparam t_cfg_idx CFG_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT = 2'd2;

    // item actions
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // neighbour select: bit 1 picks the lower row, bit 0 the right column
    typedef logic [1:0] t_corner;
    localparam t_corner CORNER_TL = 2'd0;
    localparam t_corner CORNER_TR = 2'd1;
    localparam t_corner CORNER_BL = 2'd2;
    localparam t_corner CORNER_BR = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_STORE,
        S_DIV,
        S_WGT,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_ACC,
        S_QDIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    write;
        logic    set_outside;
        logic    div_step;
        logic    wgt;
        logic    rd_en;
        t_corner rd_sel;
        logic    acc_en;
        logic    q_step;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic outside;
        logic in_src;
    } t_dp_status;

endpackage

FILE: hw/rtl/bui_datapath.sv
// datapath: config registers, frame store, dividers and weighted accumulator
module bui_datapath import bui_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_SCALE  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_action,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [ROW_W-1:0]      i_col,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_cfg_wr,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_outside
);

    localparam int MW    = $clog2(MAX_SCALE + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CA_W  = $clog2(MAX_WIDTH);
    localparam int RA_W  = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AD_W  = $clog2(DEPTH);
    localparam int WG_W  = 2 * MW;
    localparam int ACC_W = WG_W + PIX_W;
    localparam int HM_W  = HW + MW;
    localparam int WM_W  = WW + MW;

    // configuration registers
    logic [SCALE_W-1:0] r_scale;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;

    // captured beat
    logic               r_action;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_col;
    logic [PIX_W-1:0]   r_pix;

    // row / column division by the scale factor
    logic [ROW_W-1:0]   r_rowq, n_rowq;
    logic [ROW_W-1:0]   r_colq, n_colq;
    logic [MW-1:0]      r_rrem, n_rrem;
    logic [MW-1:0]      r_crem, n_crem;

    // neighbours and weights
    logic [RA_W-1:0]    r_r0, r_r1;
    logic [CA_W-1:0]    r_c0, r_c1;
    logic [WG_W-1:0]    r_wgt [4];
    t_corner            r_rd_sel_q;

    // accumulator doubles as remainder of the final division
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   r_dsh;
    logic [PIX_W-1:0]   r_res_pix;
    logic               r_res_out;

    // frame store
    logic [PIX_W-1:0]   mem [DEPTH];
    logic [PIX_W-1:0]   r_rdata;
    logic [AD_W-1:0]    mem_addr;
    logic [RA_W-1:0]    sel_row;
    logic [CA_W-1:0]    sel_col;

    logic [MW-1:0]      m_eff;
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic [HM_W-1:0]    hm;
    logic [WM_W-1:0]    wm;
    logic [MW:0]        trial_r, trial_c;
    logic [RA_W-1:0]    r0_n, r1_n;
    logic [CA_W-1:0]    c0_n, c1_n;
    logic [MW-1:0]      wr0, wc0;
    logic [WG_W-1:0]    msq;
    logic [ACC_W-1:0]   prod;

    // effective configuration with zero and saturation handling
    always_comb begin
        if (r_scale == '0) begin
            m_eff = MW'(1);
        end else if (32'(r_scale) > MAX_SCALE) begin
            m_eff = MW'(MAX_SCALE);
        end else begin
            m_eff = MW'(r_scale);
        end
        w_eff = (32'(r_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_width);
        h_eff = (32'(r_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_height);
    end

    // range checks on the captured beat
    assign hm = HM_W'(h_eff) * HM_W'(m_eff);
    assign wm = WM_W'(w_eff) * WM_W'(m_eff);
    assign o_status.is_read = (r_action == ACT_READ);
    assign o_status.outside = (32'(r_row) >= 32'(hm)) || (32'(r_col) >= 32'(wm));
    assign o_status.in_src  = (32'(r_row) < 32'(h_eff)) && (32'(r_col) < 32'(w_eff));

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_W'(2);
            r_width  <= DIM_W'(256);
            r_height <= DIM_W'(256);
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // one restoring step per cycle on row and column together
    always_comb begin
        trial_r = {r_rrem, r_rowq[ROW_W-1]};
        trial_c = {r_crem, r_colq[ROW_W-1]};
        if (trial_r >= {1'b0, m_eff}) begin
            n_rrem = MW'(trial_r - {1'b0, m_eff});
            n_rowq = {r_rowq[ROW_W-2:0], 1'b1};
        end else begin
            n_rrem = MW'(trial_r);
            n_rowq = {r_rowq[ROW_W-2:0], 1'b0};
        end
        if (trial_c >= {1'b0, m_eff}) begin
            n_crem = MW'(trial_c - {1'b0, m_eff});
            n_colq = {r_colq[ROW_W-2:0], 1'b1};
        end else begin
            n_crem = MW'(trial_c);
            n_colq = {r_colq[ROW_W-2:0], 1'b0};
        end
    end

    // neighbour coordinates clamped at the last row and column
    always_comb begin
        r0_n = RA_W'(r_rowq);
        c0_n = CA_W'(r_colq);
        r1_n = (32'(r0_n) + 1 < 32'(h_eff)) ? RA_W'(r0_n + 1'b1) : r0_n;
        c1_n = (32'(c0_n) + 1 < 32'(w_eff)) ? CA_W'(c0_n + 1'b1) : c0_n;
        wr0  = m_eff - r_rrem;
        wc0  = m_eff - r_crem;
        msq  = WG_W'(m_eff) * WG_W'(m_eff);
    end

    // capture, division and weight registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_row    <= i_row;
            r_col    <= i_col;
            r_pix    <= i_pixel_in;
            r_rowq   <= i_row;
            r_colq   <= i_col;
            r_rrem   <= '0;
            r_crem   <= '0;
        end else if (i_cmd.div_step) begin
            r_rowq <= n_rowq;
            r_colq <= n_colq;
            r_rrem <= n_rrem;
            r_crem <= n_crem;
        end
        if (i_cmd.wgt) begin
            r_r0     <= r0_n;
            r_r1     <= r1_n;
            r_c0     <= c0_n;
            r_c1     <= c1_n;
            r_wgt[0] <= WG_W'(wr0) * WG_W'(wc0);
            r_wgt[1] <= WG_W'(wr0) * WG_W'(r_crem);
            r_wgt[2] <= WG_W'(r_rrem) * WG_W'(wc0);
            r_wgt[3] <= WG_W'(r_rrem) * WG_W'(r_crem);
        end
    end

    // frame store address: store beat or one of the four neighbours
    always_comb begin
        if (i_cmd.write) begin
            sel_row = RA_W'(r_row);
            sel_col = CA_W'(r_col);
        end else begin
            sel_row = i_cmd.rd_sel[1] ? r_r1 : r_r0;
            sel_col = i_cmd.rd_sel[0] ? r_c1 : r_c0;
        end
        mem_addr = AD_W'(sel_row) * AD_W'(MAX_WIDTH) + AD_W'(sel_col);
    end

    // single port frame store with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[mem_addr] <= r_pix;
        end
        r_rdata <= mem[mem_addr];
    end

    // weighted accumulation of the pixel read in the previous cycle
    assign prod = ACC_W'(r_wgt[r_rd_sel_q]) * ACC_W'(r_rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_sel_q <= i_cmd.rd_sel;
        end
        if (i_cmd.wgt) begin
            r_acc     <= '0;
            r_dsh     <= ACC_W'(msq) << (Q_STEPS - 1);
            r_res_pix <= '0;
            r_res_out <= 1'b0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + prod;
        end else if (i_cmd.q_step) begin
            // quotient is below 256, so eight shifted compares suffice
            if (r_acc >= r_dsh) begin
                r_acc     <= r_acc - r_dsh;
                r_res_pix <= {r_res_pix[PIX_W-2:0], 1'b1};
            end else begin
                r_res_pix <= {r_res_pix[PIX_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end else if (i_cmd.set_outside) begin
            r_res_pix <= '0;
            r_res_out <= 1'b1;
        end
    end

    assign o_pixel_out = r_res_pix;
    assign o_outside   = r_res_out;

endmodule

FILE: hw/rtl/bui_ctrl.sv
// controller: sequences store and read items over the datapath
module bui_ctrl import bui_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign n_cnt = (r_state == S_DIV || r_state == S_QDIV) ? CNT_W'(r_cnt + 1'b1) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.is_read) begin
                    n_state = i_status.in_src ? S_STORE : S_IDLE;
                end else begin
                    n_state = i_status.outside ? S_OUT : S_DIV;
                end
            end
            S_STORE: n_state = S_IDLE;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_WGT;
            end
            S_WGT:  n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_ACC;
            S_ACC:  n_state = S_QDIV;
            S_QDIV: begin
                if (r_cnt == CNT_W'(Q_STEPS - 1)) n_state = S_OUT;
            end
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.capture = i_start;
            S_CHECK: o_cmd.set_outside = i_status.is_read && i_status.outside;
            S_STORE: o_cmd.write = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_WGT:   o_cmd.wgt = 1'b1;
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = CORNER_TL;
            end
            S_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = CORNER_TR;
                o_cmd.acc_en = 1'b1;
            end
            S_RD2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = CORNER_BL;
                o_cmd.acc_en = 1'b1;
            end
            S_RD3: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = CORNER_BR;
                o_cmd.acc_en = 1'b1;
            end
            S_ACC:   o_cmd.acc_en = 1'b1;
            S_QDIV:  o_cmd.q_step = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

FILE: hw/rtl/bilinear_integer_upscaler_core.sv
// top level of the grayscale bilinear integer upscaler
//
// Usage: an item is taken when start is high and busy is low. action low
// stores pixel_in at source (row, col); stores outside the configured source
// image are dropped and give no result. action high reads output pixel
// (row, col) of the image enlarged by scale_factor; exactly one result beat
// follows, shown on o_pixel_out / o_outside for one cycle with o_valid high.
// The receiver cannot stall, so a result beat is never held back.
// A store occupies the block for its check and its write only (the check
// alone when dropped). A read runs the row and column restoring dividers
// by the scale, stepped together, four single-port frame store reads with
// a registered read port, and the weight-normalizing divider; a read
// outside the enlarged image goes from its check straight to o_valid. One
// item is in flight at a time, so no new item is taken until busy falls.
// Config: write channel i_cfg_valid / o_cfg_ready (always ready) with
// i_cfg_index and i_cfg_data; write only while busy is low.
// Reset: synchronous, active low; config returns to scale 2, 256 x 256.
// The frame store is not cleared; read only pixels that were written.
module bilinear_integer_upscaler_core import bui_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_SCALE  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [ROW_W-1:0]      i_col,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_outside,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    bui_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // datapath and frame store
    bui_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_pixel_in  (i_pixel_in),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_pixel_out (o_pixel_out),
        .o_outside   (o_outside)
    );

    // a result beat only while an item is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat while idle");

    // block is idle again right after a result beat
    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy && !o_valid)
        else $error("block stays busy after result beat");

    // no result in the cycle right after an item is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_valid && busy)
        else $error("result beat too early");

    // an outside read carries a zero pixel
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outside |-> o_pixel_out == '0)
        else $error("outside read with nonzero pixel");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the bilinear integer upscaler core with its own pixel predictor

import bui_pkg::*;

// one expected read beat
typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             outside;
} t_out_pixel;

// shadow frame store and register copy, predicts and checks read beats
class upscale_scoreboard #(int MAX_W = 256, int MAX_H = 256, int MAX_M = 8);
    logic [PIX_W-1:0]   shadow_frame [MAX_W*MAX_H];
    bit                 written [MAX_W*MAX_H];
    logic [SCALE_W-1:0] scale_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    t_out_pixel         pending [$];
    int                 n_bad;

    function new();
        scale_reg  = 4'd2;
        width_reg  = 9'd256;
        height_reg = 9'd256;
        n_bad      = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SCALE:  scale_reg  = data[SCALE_W-1:0];
            CFG_WIDTH:  width_reg  = data;
            CFG_HEIGHT: height_reg = data;
            default: ;
        endcase
    endfunction

    // zero scale acts as one, oversize values saturate
    function int unsigned eff_scale();
        if (scale_reg == 0) return 1;
        if (scale_reg > MAX_M) return MAX_M;
        return scale_reg;
    endfunction

    function int unsigned eff_width();
        return (width_reg > MAX_W) ? MAX_W : width_reg;
    endfunction

    function int unsigned eff_height();
        return (height_reg > MAX_H) ? MAX_H : height_reg;
    endfunction

    // first of the four source corners of a read that holds no pixel yet
    function bit missing_corner(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                                output logic [ROW_W-1:0] r_miss,
                                output logic [ROW_W-1:0] c_miss);
        int unsigned m, w, h, r0, r1, c0, c1, r, c;
        r_miss = '0;
        c_miss = '0;
        m = eff_scale();
        w = eff_width();
        h = eff_height();
        if (row >= h * m || col >= w * m) return 1'b0;
        r0 = row / m;
        c0 = col / m;
        r1 = (r0 + 1 < h) ? r0 + 1 : h - 1;
        c1 = (c0 + 1 < w) ? c0 + 1 : w - 1;
        for (int k = 0; k < 4; k++) begin
            r = k[1] ? r1 : r0;
            c = k[0] ? c1 : c0;
            if (!written[r * MAX_W + c]) begin
                r_miss = ROW_W'(r);
                c_miss = ROW_W'(c);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // accepted input beat: update the store or queue the interpolated pixel
    function void note_item(logic act, logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                            logic [PIX_W-1:0] px);
        int unsigned m, w, h, r0, r1, c0, c1, fr, fc, acc;
        t_out_pixel exp_pix;
        m = eff_scale();
        w = eff_width();
        h = eff_height();
        if (act == ACT_STORE) begin
            // stores outside the source image are dropped
            if (row < h && col < w) begin
                shadow_frame[row * MAX_W + col] = px;
                written[row * MAX_W + col] = 1'b1;
            end
            return;
        end
        if (row >= h * m || col >= w * m) begin
            exp_pix.pixel   = '0;
            exp_pix.outside = 1'b1;
        end else begin
            r0 = row / m;
            c0 = col / m;
            fr = row % m;
            fc = col % m;
            r1 = (r0 + 1 < h) ? r0 + 1 : h - 1;
            c1 = (c0 + 1 < w) ? c0 + 1 : w - 1;
            acc = (m - fr) * (m - fc) * shadow_frame[r0 * MAX_W + c0]
                + (m - fr) * fc * shadow_frame[r0 * MAX_W + c1]
                + fr * (m - fc) * shadow_frame[r1 * MAX_W + c0]
                + fr * fc * shadow_frame[r1 * MAX_W + c1];
            exp_pix.pixel   = PIX_W'(acc / (m * m));
            exp_pix.outside = 1'b0;
        end
        pending.push_back(exp_pix);
    endfunction

    function void flag(string msg);
        n_bad++;
        if (n_bad <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // compare one result beat with the oldest expected pixel
    function void check_result(logic [PIX_W-1:0] px, logic out);
        t_out_pixel exp_pix;
        if (pending.size() == 0) begin
            flag($sformatf("unexpected beat, pixel %0d outside %0b", px, out));
            return;
        end
        exp_pix = pending.pop_front();
        if (px !== exp_pix.pixel)
            flag($sformatf("pixel_out expected %0d got %0d", exp_pix.pixel, px));
        if (out !== exp_pix.outside)
            flag($sformatf("outside expected %0b got %0b", exp_pix.outside, out));
    endfunction
endclass

module tb;
    localparam int       SRC_MAX_W     = 256;
    localparam int       SRC_MAX_H     = 256;
    localparam int       SCALE_MAX     = 8;
    localparam int       SETTLE_CYCLES = 40;
    localparam int       PHASES        = 9;
    localparam t_cfg_idx CFG_SPARE     = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_action;
    logic [ROW_W-1:0]      i_row;
    logic [ROW_W-1:0]      i_col;
    logic [PIX_W-1:0]      i_pixel_in;
    logic                  o_valid;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_outside;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    upscale_scoreboard #(SRC_MAX_W, SRC_MAX_H, SCALE_MAX) sb;
    int idle_pct;

    bilinear_integer_upscaler_core #(
        .MAX_WIDTH (SRC_MAX_W),
        .MAX_HEIGHT(SRC_MAX_H),
        .MAX_SCALE (SCALE_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_action   (i_action),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_pixel_in (i_pixel_in),
        .o_valid    (o_valid),
        .o_pixel_out(o_pixel_out),
        .o_outside  (o_outside),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result beats, sampled with their pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_result(o_pixel_out, o_outside);
    end

    // one input beat: idle cycles at the current rate, then hold start until taken
    task automatic send_item(logic act, logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                             logic [PIX_W-1:0] px);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_action   <= act;
        i_row      <= row;
        i_col      <= col;
        i_pixel_in <= px;
        do @(posedge i_clk); while (busy);
        sb.note_item(act, row, col, px);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // stop issuing and let the last read and any store finish
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return '0;
        if (sel < 4) return '1;
        return PIX_W'($urandom);
    endfunction

    // fill any unwritten source corner first, then read
    task automatic read_pixel(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col);
        logic [ROW_W-1:0] r_miss, c_miss;
        while (sb.missing_corner(row, col, r_miss, c_miss))
            send_item(ACT_STORE, r_miss, c_miss, pick_pixel());
        send_item(ACT_READ, row, col, PIX_W'($urandom));
    endtask

    // register settings per phase, extremes and saturation among them
    task automatic set_phase(int k);
        logic [CFG_DATA_W-1:0] s, w, h;
        case (k)
            0:       begin s = 9'd3;   w = 9'd5;   h = 9'd4;   end
            1:       begin s = 9'd1;   w = 9'd1;   h = 9'd1;   end
            2:       begin s = 9'd8;   w = 9'd256; h = 9'd256; end
            3:       begin s = 9'h1F0; w = 9'd7;   h = 9'd3;   end  // scale field zero
            4:       begin s = 9'd15;  w = 9'd511; h = 9'd300; end  // all saturate
            5:       begin s = 9'd5;   w = 9'd0;   h = 9'd9;   end  // empty image
            6:       begin s = 9'd4;   w = 9'd12;  h = 9'd0;   end  // empty image
            7:       begin s = 9'd2;   w = 9'd2;   h = 9'd2;   end
            default: begin s = 9'd7;   w = 9'd16;  h = 9'd9;   end
        endcase
        drain();
        // index past the register list is dropped
        if (k == 0) write_cfg(CFG_SPARE, CFG_DATA_W'($urandom));
        write_cfg(CFG_SCALE, s);
        write_cfg(CFG_WIDTH, w);
        write_cfg(CFG_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    // random mix of reads, in-image stores and stray stores
    task automatic run_random(int n);
        int unsigned sel, m, w, h, rows_up, cols_up;
        logic [ROW_W-1:0] r, c;
        for (int k = 0; k < n; k++) begin
            sel     = $urandom_range(0, 99);
            m       = sb.eff_scale();
            w       = sb.eff_width();
            h       = sb.eff_height();
            rows_up = h * m;
            cols_up = w * m;
            r       = ROW_W'($urandom);
            c       = ROW_W'($urandom);
            if (sel < 55) begin
                if (sel >= 8 && rows_up > 0 && cols_up > 0) begin
                    r = ROW_W'($urandom_range(0, rows_up - 1));
                    c = ROW_W'($urandom_range(0, cols_up - 1));
                    // lean on the clamped last row and column
                    if ($urandom_range(0, 3) == 0) r = ROW_W'(rows_up - 1);
                    if ($urandom_range(0, 3) == 0) c = ROW_W'(cols_up - 1);
                end else if (sel >= 4) begin
                    // just past the enlarged image
                    if (sel < 6 && rows_up < 2048) r = ROW_W'(rows_up);
                    if (sel >= 6 && cols_up < 2048) c = ROW_W'(cols_up);
                end
                read_pixel(r, c);
            end else if (sel < 85 && w > 0 && h > 0) begin
                send_item(ACT_STORE, ROW_W'($urandom_range(0, h - 1)),
                          ROW_W'($urandom_range(0, w - 1)), pick_pixel());
            end else begin
                send_item(ACT_STORE, r, c, pick_pixel());
            end
        end
    endtask

    // main sequence
    initial begin
        sb          = new();
        idle_pct    = 15;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_action    <= ACT_STORE;
        i_row       <= '0;
        i_col       <= '0;
        i_pixel_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SCALE;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: scale 2 over 256 x 256
        send_item(ACT_STORE, 0, 0, 8'hFF);
        send_item(ACT_STORE, 0, 1, 8'h00);
        send_item(ACT_STORE, 1, 0, 8'h00);
        send_item(ACT_STORE, 1, 1, 8'hFF);
        read_pixel(0, 0);
        read_pixel(1, 1);
        read_pixel(0, 1);
        read_pixel(1, 0);
        // bottom right corner, clamped neighbours
        send_item(ACT_STORE, 255, 255, 8'hFF);
        send_item(ACT_STORE, 255, 254, 8'h80);
        send_item(ACT_STORE, 254, 255, 8'h01);
        send_item(ACT_STORE, 254, 254, 8'hFE);
        read_pixel(511, 511);
        read_pixel(509, 510);
        // stores past the source image are dropped
        send_item(ACT_STORE, 256, 0, 8'hAA);
        send_item(ACT_STORE, 0, 256, 8'h55);
        send_item(ACT_STORE, 2047, 2047, 8'hAA);
        // reads past the enlarged image
        read_pixel(512, 0);
        read_pixel(0, 512);
        read_pixel(2047, 2047);
        read_pixel(511, 2047);

        for (int k = 0; k < PHASES; k++) begin
            if (k == 3) idle_pct = 66;
            if (k == 6) idle_pct = 0;
            set_phase(k);
            run_random(55);
        end
        drain();

        if (sb.n_bad == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/bui_pkg.sv
hw/rtl/bui_datapath.sv
hw/rtl/bui_ctrl.sv
hw/rtl/bilinear_integer_upscaler_core.sv
tb/tb.sv
